### rtl/affine_point_transform_macros.svh
// ----------------------------------------------------------------------------
// affine point transform assertion macros
// concurrent check wrappers, compiled away for synthesis
// ----------------------------------------------------------------------------
`ifndef AFFINE_POINT_TRANSFORM_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define APT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// next-cycle implication
`define APT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define APT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define APT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// types, codes and helper functions of the affine point transform
// ----------------------------------------------------------------------------
`default_nettype none

package apt_pkg;

	// one quotient bit per divider stage
	localparam int DIV_STEPS = 32;

	localparam logic signed [31:0] COEF_ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] COEF_ZERO = 32'sh0000_0000;
	localparam logic [31:0]        SAT_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0]        SAT_MIN   = 32'h8000_0000;

	// operation selector
	typedef enum logic {
		OP_FORWARD = 1'b0,
		OP_INVERSE = 1'b1
	} op_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_COEF_XX       = 3'd0,
		REG_COEF_XY       = 3'd1,
		REG_COEF_X_OFFSET = 3'd2,
		REG_COEF_YX       = 3'd3,
		REG_COEF_YY       = 3'd4,
		REG_COEF_Y_OFFSET = 3'd5
	} cfg_reg_t;

	// one result beat
	typedef struct packed {
		logic [31:0] rx;
		logic [31:0] ry;
		logic        sing;
		logic        ovf;
	} result_t;

	// saturated coordinate and its overflow flag
	typedef struct packed {
		logic [31:0] val;
		logic        ovf;
	} sat_t;

	// one divider lane: partial remainder, numerator bits shifting out
	// while quotient bits shift in, and the quotient-too-large flag
	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] nq;
		logic        big;
	} div_lane_t;

	// everything that rides along one divider stage
	typedef struct packed {
		op_t         op;
		logic        sing;
		logic        neg_x;
		logic        neg_y;
		logic [63:0] den;
		div_lane_t   lx;
		div_lane_t   ly;
		result_t     fwd;
	} div_stage_t;

	// q32.32 sum already biased by one half lsb, to q16.16 with clamp
	function automatic sat_t sat_round(input logic signed [65:0] t);
		sat_t r;
		logic fits;
		fits = (&t[65:47]) | (~|t[65:47]);
		r.ovf = ~fits;
		if (fits) begin
			r.val = t[47:16];
		end else if (t[65]) begin
			r.val = SAT_MIN;
		end else begin
			r.val = SAT_MAX;
		end
		return r;
	endfunction

	// unsigned quotient magnitude plus sign, to clamped two's complement
	function automatic sat_t sat_quot(input logic [31:0] q, input logic big,
	                                  input logic neg);
		sat_t r;
		r.ovf = 1'b0;
		if (neg) begin
			if (big || (q > SAT_MIN)) begin
				r.val = SAT_MIN;
				r.ovf = 1'b1;
			end else begin
				r.val = ~q + 32'd1;
			end
		end else begin
			if (big || q[31]) begin
				r.val = SAT_MAX;
				r.ovf = 1'b1;
			end else begin
				r.val = q;
			end
		end
		return r;
	endfunction

	// one restoring division step
	function automatic div_lane_t div_step(input div_lane_t l, input logic [63:0] den);
		div_lane_t r;
		logic [64:0] t;
		logic        ge;
		t = {l.rem, l.nq[31]};
		ge = (t >= {1'b0, den});
		r.big = l.big;
		r.nq = {l.nq[30:0], ge};
		if (ge) begin
			r.rem = 64'(t - {1'b0, den});
		end else begin
			r.rem = t[63:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/affine_point_transform.sv
// ----------------------------------------------------------------------------
// affine_point_transform
// forward and inverse 2d affine map of one q16.16 point per beat
// ----------------------------------------------------------------------------
//
// channel   direction  beat contents
// s_axis    in         tdata {point_y, point_x}, tuser {operation}
// m_axis    out        tdata {result_y, result_x}, tuser {overflow, singular}
// cfg       in         one coefficient write per cycle, no read-back
//
// one point enters per cycle while the output buffer has room
// most of the pipeline is the 32-stage restoring divider, one quotient bit per stage
// a two-entry output buffer takes results; the input is held off only while
// both entries are full, and then every stage holds its contents
// reset clears the valid bits and loads the identity coefficients
//
`default_nettype none

`include "affine_point_transform_macros.svh"

module affine_point_transform
	import apt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [31:0] point_x, [63:32] point_y
	input  wire logic [0:0]  s_axis_tuser,   // [0] operation
	// output stream
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [63:0] m_axis_tdata,   // [31:0] result_x, [63:32] result_y
	output      logic [1:0]  m_axis_tuser,   // [0] singular, [1] overflow
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata
);

	// coefficient registers
	logic signed [31:0] coef_xx_q, coef_xy_q, coef_x_offset_q;
	logic signed [31:0] coef_yx_q, coef_yy_q, coef_y_offset_q;

	// pipeline advance and output buffer
	logic       adv;
	logic       push, pop;
	logic [1:0] cnt_q;
	result_t    buf0_q, buf1_q;
	result_t    res_out;

	// stage 1: operands
	logic               vld_s1;
	op_t                op_s1;
	logic signed [32:0] mx_s1, my_s1;

	// stage 2: products
	logic               vld_s2;
	op_t                op_s2;
	logic signed [64:0] p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [63:0] pae_s2, pbd_s2;

	// stage 3: sums and determinant
	logic               vld_s3;
	op_t                op_s3;
	logic signed [65:0] sumx_s3, sumy_s3;
	logic signed [63:0] det_s3;

	// stage 4: forward result, inverse magnitudes
	logic               vld_s4;
	op_t                op_s4;
	result_t            fwd_s4;
	logic [63:0]        nmag_x_s4, nmag_y_s4;
	logic [62:0]        dmag_s4;
	logic               neg_x_s4, neg_y_s4, sing_s4;

	// stage 5: scaled numerators and divisor
	logic               vld_s5;
	op_t                op_s5;
	result_t            fwd_s5;
	logic [81:0]        num_x_s5, num_y_s5;
	logic [63:0]        den_s5;
	logic               neg_x_s5, neg_y_s5, sing_s5;

	// divider stages, entry k is pipeline stage 6 + k
	logic               div_vld_s [0:DIV_STEPS];
	div_stage_t         div_s     [0:DIV_STEPS];

	// combinational helpers
	logic signed [31:0] in_x, in_y;
	op_t                in_op;
	logic signed [32:0] in_u, in_v;
	logic signed [31:0] cm1, cm4;
	logic signed [65:0] tx, ty;
	logic signed [65:0] nabs_x, nabs_y;
	logic signed [63:0] dabs;
	sat_t               fsx, fsy, qsx, qsy;

	// configuration writes, out-of-range index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q       <= COEF_ONE;
			coef_xy_q       <= COEF_ZERO;
			coef_x_offset_q <= COEF_ZERO;
			coef_yx_q       <= COEF_ZERO;
			coef_yy_q       <= COEF_ONE;
			coef_y_offset_q <= COEF_ZERO;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_COEF_XX:       coef_xx_q       <= cfg_wdata;
				REG_COEF_XY:       coef_xy_q       <= cfg_wdata;
				REG_COEF_X_OFFSET: coef_x_offset_q <= cfg_wdata;
				REG_COEF_YX:       coef_yx_q       <= cfg_wdata;
				REG_COEF_YY:       coef_yy_q       <= cfg_wdata;
				REG_COEF_Y_OFFSET: coef_y_offset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// the whole pipe moves unless the output buffer is full
	assign adv           = (cnt_q != 2'd2);
	assign s_axis_tready = adv;

	// input beat unpacking, inverse works on offset-removed point
	assign in_x  = s_axis_tdata[31:0];
	assign in_y  = s_axis_tdata[63:32];
	assign in_op = op_t'(s_axis_tuser[0]);
	assign in_u  = 33'(in_x) - 33'(coef_x_offset_q);
	assign in_v  = 33'(in_y) - 33'(coef_y_offset_q);

	// multiplier coefficient swap for the inverse numerators
	assign cm1 = (op_s1 == OP_INVERSE) ? coef_yy_q : coef_xx_q;
	assign cm4 = (op_s1 == OP_INVERSE) ? coef_xx_q : coef_yy_q;

	// forward rounding and clamp
	always_comb begin
		tx  = sumx_s3 + 66'($signed({coef_x_offset_q, 16'h0000})) + 66'sd32768;
		ty  = sumy_s3 + 66'($signed({coef_y_offset_q, 16'h0000})) + 66'sd32768;
		fsx = sat_round(tx);
		fsy = sat_round(ty);
	end

	// inverse magnitudes
	always_comb begin
		nabs_x = sumx_s3[65] ? -sumx_s3 : sumx_s3;
		nabs_y = sumy_s3[65] ? -sumy_s3 : sumy_s3;
		dabs   = det_s3[63] ? -det_s3 : det_s3;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) begin
				div_vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1       <= s_axis_tvalid;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_s4       <= vld_s3;
			vld_s5       <= vld_s4;
			div_vld_s[0] <= vld_s5;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				div_vld_s[k] <= div_vld_s[k-1];
			end
		end
	end

	// stages 1 to 5 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			// operands
			op_s1 <= in_op;
			mx_s1 <= (in_op == OP_INVERSE) ? in_u : 33'(in_x);
			my_s1 <= (in_op == OP_INVERSE) ? in_v : 33'(in_y);

			// products
			op_s2  <= op_s1;
			p1_s2  <= cm1 * mx_s1;
			p2_s2  <= coef_xy_q * my_s1;
			p3_s2  <= coef_yx_q * mx_s1;
			p4_s2  <= cm4 * my_s1;
			pae_s2 <= coef_xx_q * coef_yy_q;
			pbd_s2 <= coef_xy_q * coef_yx_q;

			// sums, numerators and determinant
			op_s3 <= op_s2;
			if (op_s2 == OP_INVERSE) begin
				sumx_s3 <= 66'(p1_s2) - 66'(p2_s2);
				sumy_s3 <= 66'(p4_s2) - 66'(p3_s2);
			end else begin
				sumx_s3 <= 66'(p1_s2) + 66'(p2_s2);
				sumy_s3 <= 66'(p3_s2) + 66'(p4_s2);
			end
			det_s3 <= pae_s2 - pbd_s2;

			// forward result done, inverse split into sign and magnitude
			op_s4       <= op_s3;
			fwd_s4.rx   <= fsx.val;
			fwd_s4.ry   <= fsy.val;
			fwd_s4.sing <= 1'b0;
			fwd_s4.ovf  <= fsx.ovf | fsy.ovf;
			nmag_x_s4   <= nabs_x[63:0];
			nmag_y_s4   <= nabs_y[63:0];
			dmag_s4     <= dabs[62:0];
			neg_x_s4    <= sumx_s3[65] ^ det_s3[63];
			neg_y_s4    <= sumy_s3[65] ^ det_s3[63];
			sing_s4     <= (det_s3 == 64'sd0);

			// rounded quotient as floor((n * 2^17 + d) / (2 * d))
			op_s5    <= op_s4;
			fwd_s5   <= fwd_s4;
			num_x_s5 <= 82'({nmag_x_s4, 17'h0}) + 82'(dmag_s4);
			num_y_s5 <= 82'({nmag_y_s4, 17'h0}) + 82'(dmag_s4);
			den_s5   <= {dmag_s4, 1'b0};
			neg_x_s5 <= neg_x_s4;
			neg_y_s5 <= neg_y_s4;
			sing_s5  <= sing_s4;
		end
	end

	// divider: upper numerator bits checked for a too-large quotient,
	// then one quotient bit per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].op     <= op_s5;
			div_s[0].sing   <= sing_s5;
			div_s[0].neg_x  <= neg_x_s5;
			div_s[0].neg_y  <= neg_y_s5;
			div_s[0].den    <= den_s5;
			div_s[0].fwd    <= fwd_s5;
			div_s[0].lx.rem <= 64'(num_x_s5[81:32]);
			div_s[0].lx.nq  <= num_x_s5[31:0];
			div_s[0].lx.big <= (64'(num_x_s5[81:32]) >= den_s5);
			div_s[0].ly.rem <= 64'(num_y_s5[81:32]);
			div_s[0].ly.nq  <= num_y_s5[31:0];
			div_s[0].ly.big <= (64'(num_y_s5[81:32]) >= den_s5);
			for (int k = 1; k <= DIV_STEPS; k++) begin
				div_s[k].op    <= div_s[k-1].op;
				div_s[k].sing  <= div_s[k-1].sing;
				div_s[k].neg_x <= div_s[k-1].neg_x;
				div_s[k].neg_y <= div_s[k-1].neg_y;
				div_s[k].den   <= div_s[k-1].den;
				div_s[k].fwd   <= div_s[k-1].fwd;
				div_s[k].lx    <= div_step(div_s[k-1].lx, div_s[k-1].den);
				div_s[k].ly    <= div_step(div_s[k-1].ly, div_s[k-1].den);
			end
		end
	end

	// final selection: forward, singular or clamped quotient
	always_comb begin
		qsx = sat_quot(div_s[DIV_STEPS].lx.nq, div_s[DIV_STEPS].lx.big,
		               div_s[DIV_STEPS].neg_x);
		qsy = sat_quot(div_s[DIV_STEPS].ly.nq, div_s[DIV_STEPS].ly.big,
		               div_s[DIV_STEPS].neg_y);
		if (div_s[DIV_STEPS].op == OP_FORWARD) begin
			res_out = div_s[DIV_STEPS].fwd;
		end else if (div_s[DIV_STEPS].sing) begin
			res_out.rx   = 32'h0;
			res_out.ry   = 32'h0;
			res_out.sing = 1'b1;
			res_out.ovf  = 1'b0;
		end else begin
			res_out.rx   = qsx.val;
			res_out.ry   = qsy.val;
			res_out.sing = 1'b0;
			res_out.ovf  = qsx.ovf | qsy.ovf;
		end
	end

	// output buffer handshake
	assign push = div_vld_s[DIV_STEPS] && adv;
	assign pop  = (cnt_q != 2'd0) && m_axis_tready;

	// output buffer fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// output buffer entries, head in buf0
	always_ff @(posedge clk) begin
		if (push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))) begin
			buf0_q <= res_out;
		end else if (pop && (cnt_q == 2'd2)) begin
			buf0_q <= buf1_q;
		end
		if (push && (cnt_q == 2'd1) && !pop) begin
			buf1_q <= res_out;
		end
	end

	// output beat packing
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = {buf0_q.ry, buf0_q.rx};
	assign m_axis_tuser  = {buf0_q.ovf, buf0_q.sing};

	// checks
	`APT_ASSERT_SAME(a_sing_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == 64'h0) && !m_axis_tuser[1])
	`APT_ASSERT_SAME(a_ovf_clamped, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], (m_axis_tdata[31:0] == SAT_MAX) || (m_axis_tdata[31:0] == SAT_MIN) || (m_axis_tdata[63:32] == SAT_MAX) || (m_axis_tdata[63:32] == SAT_MIN))
	`APT_ASSERT_SAME(a_buf_full_cause, clk, arst_n, cnt_q == 2'd2, $past(push && !pop) || $past(cnt_q == 2'd2))
	`APT_ASSERT_NEXT(a_no_phantom, clk, arst_n, (cnt_q == 2'd0) && !div_vld_s[DIV_STEPS], !m_axis_tvalid)

endmodule

`default_nettype wire

### tb/tb_affine_point_transform.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_affine_point_transform
// self-checking bench for the forward and inverse q16.16 affine point map
// ----------------------------------------------------------------------------
//
// queued points feed a burst driver with random gaps, the receiver stalls
// on patterns of its own
// each accepted input beat goes through a predictor with 128-bit integer math,
// each output beat is compared field by field with the oldest prediction
// coefficients change only while the pipe is empty
// directed sets for rounding ties, saturation, a zero determinant and
// extreme coefficients, then random sets
//

module tb_affine_point_transform
	import apt_pkg::*;
();

	// register indexes past the last coefficient, writes there are dropped
	localparam logic [2:0] CFG_SPARE_6 = 3'd6;
	localparam logic [2:0] CFG_SPARE_7 = 3'd7;

	// kinds of random coefficient sets
	localparam int SET_SMALL = 0;
	localparam int SET_WILD  = 1;
	localparam int SET_EDGE  = 2;
	localparam int SET_FLAT  = 3;

	// receiver stall patterns
	localparam int RX_OPEN    = 0;
	localparam int RX_COIN    = 1;
	localparam int RX_LULL    = 2;
	localparam int RX_TRICKLE = 3;

	localparam logic signed [127:0] COORD_TOP    = 128'sd2147483647;
	localparam logic signed [127:0] COORD_BOTTOM = -128'sd2147483648;

	typedef struct packed {
		op_t         op;
		logic [31:0] px;
		logic [31:0] py;
	} point_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // [31:0] point_x, [63:32] point_y
	logic [0:0]  s_axis_tuser = '0;   // [0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;        // [31:0] result_x, [63:32] result_y
	logic [1:0]  m_axis_tuser;        // [0] singular, [1] overflow
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;

	// coefficients as the block holds them, reset is the identity map
	logic signed [31:0] coef_now [6] = '{COEF_ONE, COEF_ZERO, COEF_ZERO,
	                                    COEF_ZERO, COEF_ONE, COEF_ZERO};

	point_beat_t pending_points [$];
	result_t     expected_results [$];

	point_beat_t beat;
	result_t     got_beat;
	result_t     want_beat;
	bit          in_taken;
	int          gap_left = 0;
	int          burst_left = 1;
	int          rx_mode = RX_OPEN;
	int          rx_cycle = 0;
	int          stall_left = 0;
	int          err_count = 0;
	int          n_forward = 0;
	int          n_inverse = 0;
	int          n_results = 0;
	int          n_singular = 0;
	int          n_saturated = 0;
	int          n_sets = 0;

	affine_point_transform i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// clamp to 32 bits, {overflow, value}
	function automatic logic [32:0] clamp_coord(input logic signed [127:0] t);
		if (t > COORD_TOP)
			return {1'b1, SAT_MAX};
		if (t < COORD_BOTTOM)
			return {1'b1, SAT_MIN};
		return {1'b0, t[31:0]};
	endfunction

	// num / den in q16.16, nearest, ties away from zero
	function automatic logic signed [127:0] quot_nearest(input logic signed [127:0] num,
	                                                     input logic signed [127:0] den);
		logic [127:0] mag_n, mag_d, q;
		mag_n = num[127] ? -num : num;
		mag_d = den[127] ? -den : den;
		q = ((mag_n << 17) + mag_d) / (mag_d << 1);
		return (num[127] != den[127]) ? -$signed(q) : $signed(q);
	endfunction

	function automatic result_t map_point(input op_t op, input logic signed [31:0] px,
	                                      input logic signed [31:0] py);
		logic signed [127:0] xx, xy, xo, yx, yy, yo, x, y, u, v, det, sum_x, sum_y;
		logic [32:0] cx, cy;
		result_t r;
		xx = coef_now[REG_COEF_XX];
		xy = coef_now[REG_COEF_XY];
		xo = coef_now[REG_COEF_X_OFFSET];
		yx = coef_now[REG_COEF_YX];
		yy = coef_now[REG_COEF_YY];
		yo = coef_now[REG_COEF_Y_OFFSET];
		x = px;
		y = py;
		r.sing = 1'b0;
		if (op == OP_FORWARD) begin
			// exact q32.32 sums, half lsb added, then floor to q16.16
			sum_x = xx * x + xy * y + (xo <<< 16) + 128'sd32768;
			sum_y = yx * x + yy * y + (yo <<< 16) + 128'sd32768;
			cx = clamp_coord(sum_x >>> 16);
			cy = clamp_coord(sum_y >>> 16);
		end else begin
			u = x - xo;
			v = y - yo;
			det = xx * yy - xy * yx;
			if (det == 0) begin
				cx = '0;
				cy = '0;
				r.sing = 1'b1;
			end else begin
				cx = clamp_coord(quot_nearest(yy * u - xy * v, det));
				cy = clamp_coord(quot_nearest(xx * v - yx * u, det));
			end
		end
		r.rx = cx[31:0];
		r.ry = cy[31:0];
		r.ovf = cx[32] | cy[32];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		err_count++;
	endtask

	task automatic queue_point(input op_t op, input logic [31:0] px, input logic [31:0] py);
		point_beat_t p;
		p.op = op;
		p.px = px;
		p.py = py;
		pending_points.push_back(p);
	endtask

	// block until every queued point has gone through and come back
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_points.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
	endtask

	task automatic write_coef(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		if (idx <= REG_COEF_Y_OFFSET)
			coef_now[idx] = val;
	endtask

	task automatic load_coefs(input logic [31:0] c_xx, input logic [31:0] c_xy,
	                          input logic [31:0] c_xo, input logic [31:0] c_yx,
	                          input logic [31:0] c_yy, input logic [31:0] c_yo);
		write_coef(REG_COEF_XX, c_xx);
		write_coef(REG_COEF_XY, c_xy);
		write_coef(REG_COEF_X_OFFSET, c_xo);
		write_coef(REG_COEF_YX, c_yx);
		write_coef(REG_COEF_YY, c_yy);
		write_coef(REG_COEF_Y_OFFSET, c_yo);
		@(negedge clk);
		cfg_we <= 1'b0;
		n_sets++;
	endtask

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 4))
			0: return SAT_MIN;
			1: return SAT_MAX;
			2: return COEF_ZERO;
			3: return COEF_ONE;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] rand_coef(input int kind, input bit is_offset);
		int s;
		case (kind)
			SET_WILD: return $urandom();
			SET_EDGE: return ($urandom_range(0, 1) == 0) ? edge_value() : $urandom();
			default: begin
				// weights within +-4.0, offsets within +-1000.0
				if (is_offset)
					s = int'($urandom_range(0, 131072000)) - 65536000;
				else
					s = int'($urandom_range(0, 524288)) - 262144;
				return s;
			end
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		int s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4, 5, 6: begin
				s = int'($urandom_range(0, 2097152)) - 1048576;
				return s;
			end
			7, 8: begin
				s = int'($urandom_range(0, 134217728)) - 67108864;
				return s;
			end
			default: return edge_value();
		endcase
	endfunction

	// ------------------------------------------------------------------
	// input driver: bursts of random length with random gaps
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_points.size() != 0) begin
				beat = pending_points.pop_front();
				s_axis_tdata <= {beat.py, beat.px};
				s_axis_tuser <= beat.op;
				s_axis_tvalid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
					                                         : $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// output stall pattern, mode redrawn at random from a free-running cycle count
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			rx_mode = $urandom_range(RX_OPEN, RX_TRICKLE);
		case (rx_mode)
			RX_OPEN: m_axis_tready <= 1'b1;
			RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
			RX_LULL: begin
				if (stall_left > 0) begin
					stall_left--;
					m_axis_tready <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					stall_left = $urandom_range(4, 24);
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// monitor: predict on input beats, compare on output beats
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		in_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_taken) begin
			if (s_axis_tuser[0] == OP_INVERSE)
				n_inverse++;
			else
				n_forward++;
			expected_results.push_back(map_point(op_t'(s_axis_tuser[0]),
			                                     s_axis_tdata[31:0], s_axis_tdata[63:32]));
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_beat.rx = m_axis_tdata[31:0];
			got_beat.ry = m_axis_tdata[63:32];
			got_beat.sing = m_axis_tuser[0];
			got_beat.ovf = m_axis_tuser[1];
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result beat %h/%b with nothing pending",
				                          m_axis_tdata, m_axis_tuser));
			end else begin
				want_beat = expected_results.pop_front();
				if (got_beat.rx !== want_beat.rx)
					report_mismatch($sformatf("result_x %h, want %h (beat %0d)",
					                          got_beat.rx, want_beat.rx, n_results));
				if (got_beat.ry !== want_beat.ry)
					report_mismatch($sformatf("result_y %h, want %h (beat %0d)",
					                          got_beat.ry, want_beat.ry, n_results));
				if (got_beat.sing !== want_beat.sing)
					report_mismatch($sformatf("singular %b, want %b (beat %0d)",
					                          got_beat.sing, want_beat.sing, n_results));
				if (got_beat.ovf !== want_beat.ovf)
					report_mismatch($sformatf("overflow %b, want %b (beat %0d)",
					                          got_beat.ovf, want_beat.ovf, n_results));
				n_singular += want_beat.sing;
				n_saturated += want_beat.ovf;
			end
			n_results++;
		end
	end

	// ------------------------------------------------------------------
	// sequence of coefficient sets and points
	// ------------------------------------------------------------------
	initial begin
		int p, k, kind;
		logic [31:0] c [6];

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// identity coefficients straight out of reset
		queue_point(OP_FORWARD, 32'h0000_0000, 32'h0000_0000);
		queue_point(OP_FORWARD, SAT_MAX, SAT_MIN);
		queue_point(OP_INVERSE, SAT_MIN, SAT_MAX);
		queue_point(OP_INVERSE, 32'hFFFF_FFFF, 32'h0000_0001);
		queue_point(OP_FORWARD, 32'h0000_0001, 32'hFFFF_FFFF);
		queue_point(OP_INVERSE, 32'h0000_0000, 32'h0000_0000);
		wait_idle();

		// scale by 2.0: inverse half-lsb ties go away from zero, forward clamps
		load_coefs(32'h0002_0000, COEF_ZERO, COEF_ZERO, COEF_ZERO, 32'h0002_0000, COEF_ZERO);
		queue_point(OP_INVERSE, 32'h0000_0001, 32'hFFFF_FFFF);
		queue_point(OP_INVERSE, 32'h0000_0003, 32'hFFFF_FFFD);
		queue_point(OP_FORWARD, SAT_MAX, SAT_MIN);
		queue_point(OP_FORWARD, 32'h4000_0000, 32'h0000_0000);
		queue_point(OP_FORWARD, 32'h3FFF_FFFF, 32'hC000_0000);
		queue_point(OP_INVERSE, SAT_MAX, SAT_MIN);
		wait_idle();

		// scale by +0.5 and -0.5: forward half-lsb ties go toward plus infinity
		load_coefs(32'h0000_8000, COEF_ZERO, COEF_ZERO, COEF_ZERO, 32'hFFFF_8000, COEF_ZERO);
		queue_point(OP_FORWARD, 32'h0000_0001, 32'h0000_0001);
		queue_point(OP_FORWARD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_point(OP_INVERSE, 32'h0000_0001, 32'h0000_0001);
		queue_point(OP_INVERSE, SAT_MAX, SAT_MIN);
		wait_idle();

		// all-ones matrix, zero determinant; spare indexes must be ignored
		write_coef(CFG_SPARE_6, 32'h5A5A_A5A5);
		write_coef(CFG_SPARE_7, 32'hA5A5_5A5A);
		load_coefs(COEF_ONE, COEF_ONE, 32'h0000_0005, COEF_ONE, COEF_ONE, COEF_ZERO);
		queue_point(OP_INVERSE, 32'h0000_0005, 32'h0000_0007);
		queue_point(OP_FORWARD, 32'h0000_0001, 32'h0000_0002);
		queue_point(OP_INVERSE, SAT_MIN, SAT_MAX);
		queue_point(OP_FORWARD, SAT_MAX, SAT_MAX);
		wait_idle();

		// extreme coefficients in both polarities
		load_coefs(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN);
		queue_point(OP_FORWARD, SAT_MIN, SAT_MAX);
		queue_point(OP_INVERSE, SAT_MAX, SAT_MIN);
		wait_idle();
		load_coefs(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX);
		queue_point(OP_FORWARD, SAT_MAX, SAT_MIN);
		queue_point(OP_INVERSE, SAT_MIN, SAT_MAX);
		wait_idle();

		// random coefficient sets with random points
		for (p = 0; p < 8; p++) begin
			kind = p % 4;
			for (k = 0; k < 6; k++)
				c[k] = rand_coef(kind, (k == REG_COEF_X_OFFSET) || (k == REG_COEF_Y_OFFSET));
			if (kind == SET_FLAT) begin
				// rows proportional, so the determinant is zero
				c[REG_COEF_YX] = c[REG_COEF_XX];
				c[REG_COEF_YY] = c[REG_COEF_XY];
			end
			load_coefs(c[0], c[1], c[2], c[3], c[4], c[5]);
			for (k = 0; k < 80; k++) begin
				queue_point(op_t'($urandom_range(0, 1)), rand_coord(), rand_coord());
				// hold the sender once until the pipe has fully drained
				if (p == 3 && k == 39)
					wait_idle();
			end
			wait_idle();
		end

		// let any stray result show up before closing
		repeat (60) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("covered %0d points (%0d forward, %0d inverse) over %0d coefficient sets",
		         n_forward + n_inverse, n_forward, n_inverse, n_sets + 1);
		$display("checked %0d results, %0d singular, %0d saturated, %0d mismatches",
		         n_results, n_singular, n_saturated, err_count);
		if (err_count == 0)
			$display("tb_affine_point_transform: done, clean");
		else
			$display("tb_affine_point_transform: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("tb_affine_point_transform: done, errors");
		$finish;
	end

endmodule
